// ===== rtl/tlcf_pkg.sv =====
`timescale 1ns / 1ps
package tlcf_pkg;

  localparam int IdW = 16;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  localparam logic [1:0] SEL_A = 2'd0;
  localparam logic [1:0] SEL_B = 2'd1;
  localparam logic [1:0] SEL_C = 2'd2;

  localparam logic signed [IdW-1:0] NO_ID      = -16'sd1;
  localparam logic signed [IdW-1:0] ORC_RESET  = -16'sd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WALK,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load_in;
    logic exec;
    logic walk;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic walk_done;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/tlcf_ctrl.sv =====
`timescale 1ns / 1ps
module tlcf_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  tlcf_pkg::status_t status,
  output tlcf_pkg::cmd_t    cmd
);
  import tlcf_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (s_tvalid) state_next = ST_EXEC;
      ST_EXEC: state_next = ST_WALK;
      ST_WALK: if (status.walk_done) state_next = ST_EMIT;
      ST_EMIT: if (status.out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready    = 1'b0;
    cmd         = '0;
    unique case (state)
      ST_IDLE: begin
        s_tready    = !rst;
        cmd.load_in = s_tvalid && !rst;
      end
      ST_EXEC: cmd.exec = 1'b1;
      ST_WALK: cmd.walk = 1'b1;
      ST_EMIT: cmd.emit = status.out_free;
      default: ;
    endcase
  end

endmodule

// ===== rtl/tlcf_datapath.sv =====
`timescale 1ns / 1ps
module tlcf_datapath #(
  parameter int DEPTH_A = 4,
  parameter int DEPTH_B = 4,
  parameter int DEPTH_C = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [31:0]       s_tdata,
  input  logic              cfg_valid,
  input  logic [15:0]       cfg_data,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [47:0]       m_tdata,
  input  tlcf_pkg::cmd_t    cmd,
  output tlcf_pkg::status_t status
);
  import tlcf_pkg::*;

  localparam int IWA = (DEPTH_A > 1) ? $clog2(DEPTH_A) : 1;
  localparam int IWB = (DEPTH_B > 1) ? $clog2(DEPTH_B) : 1;
  localparam int IWC = (DEPTH_C > 1) ? $clog2(DEPTH_C) : 1;
  localparam logic [4:0] DA = 5'(DEPTH_A);
  localparam logic [4:0] DB = 5'(DEPTH_B);
  localparam logic [4:0] DC = 5'(DEPTH_C);

  logic signed [IdW-1:0] list_a [DEPTH_A];
  logic signed [IdW-1:0] list_b [DEPTH_B];
  logic signed [IdW-1:0] list_c [DEPTH_C];
  logic signed [IdW-1:0] orc;

  // captured item
  logic [1:0]            op_q;
  logic [1:0]            sel_q;
  logic [3:0]            slot_q;
  logic signed [IdW-1:0] id_q;
  logic                  need_q;

  // per-item results
  logic signed [IdW-1:0] rd;
  logic                  bad;
  logic [3:0]            idx;
  logic                  found;
  logic signed [IdW-1:0] common;

  logic [3:0]            na, nb, nc;
  logic                  in_a, in_b, in_c;
  logic [IWB-1:0]        b_addr;
  logic signed [IdW-1:0] b_word;
  logic signed [IdW-1:0] cand;
  logic                  hit_a, hit_c;

  assign in_a = (sel_q == SEL_A) && ({1'b0, slot_q} < DA);
  assign in_b = (sel_q == SEL_B) && ({1'b0, slot_q} < DB);
  assign in_c = (sel_q == SEL_C) && ({1'b0, slot_q} < DC);

  // one read port on list B: the slot during execute, the walk index after
  assign b_addr = cmd.walk ? idx[IWB-1:0] : slot_q[IWB-1:0];
  assign b_word = list_b[b_addr];
  assign cand   = b_word;

  always_comb begin
    na = 4'(DEPTH_A);
    for (int i = DEPTH_A - 1; i >= 0; i--) begin
      if (list_a[i] <= 0) na = 4'(i);
    end
    nb = 4'(DEPTH_B);
    for (int i = DEPTH_B - 1; i >= 0; i--) begin
      if (list_b[i] <= 0) nb = 4'(i);
    end
    nc = 4'(DEPTH_C);
    for (int i = DEPTH_C - 1; i >= 0; i--) begin
      if (list_c[i] <= 0) nc = 4'(i);
    end
  end

  always_comb begin
    hit_a = 1'b0;
    for (int j = 0; j < DEPTH_A; j++) begin
      if ((4'(j) < na) && (list_a[j] == cand)) hit_a = 1'b1;
    end
    hit_c = 1'b0;
    for (int j = 0; j < DEPTH_C; j++) begin
      if ((4'(j) < nc) && (list_c[j] == cand)) hit_c = 1'b1;
    end
  end

  assign status.walk_done = found || (idx >= nb);
  assign status.out_free  = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      orc <= ORC_RESET;
    end else if (cfg_valid) begin
      orc <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_q   <= s_tdata[1:0];
      sel_q  <= s_tdata[3:2];
      slot_q <= s_tdata[7:4];
      id_q   <= s_tdata[23:8];
      need_q <= s_tdata[24];
    end
  end

  // lists and execute
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH_A; i++) list_a[i] <= '0;
      for (int i = 0; i < DEPTH_B; i++) list_b[i] <= '0;
      for (int i = 0; i < DEPTH_C; i++) list_c[i] <= '0;
    end else if (cmd.exec) begin
      if (op_q == OP_CLEAR) begin
        for (int i = 0; i < DEPTH_A; i++) list_a[i] <= '0;
        for (int i = 0; i < DEPTH_B; i++) list_b[i] <= '0;
        for (int i = 0; i < DEPTH_C; i++) list_c[i] <= '0;
      end else if (op_q == OP_WRITE) begin
        if (in_a) list_a[slot_q[IWA-1:0]] <= id_q;
        if (in_b) list_b[slot_q[IWB-1:0]] <= id_q;
        if (in_c) list_c[slot_q[IWC-1:0]] <= id_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rd     <= '0;
      bad    <= 1'b0;
      idx    <= '0;
      found  <= 1'b0;
      common <= NO_ID;
      if (op_q == OP_WRITE) begin
        bad <= !(in_a || in_b || in_c);
      end else if (op_q == OP_QUERY) begin
        priority if (in_a) rd <= list_a[slot_q[IWA-1:0]];
        else if (in_b)     rd <= b_word;
        else if (in_c)     rd <= list_c[slot_q[IWC-1:0]];
        else begin
          rd  <= orc;
          bad <= 1'b1;
        end
      end
    end else if (cmd.walk && !status.walk_done) begin
      idx <= idx + 4'd1;
      if (hit_c && (hit_a || !need_q)) begin
        found  <= 1'b1;
        common <= cand;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= {3'b000, common, nc, nb, na, bad, rd};
    end
  end

endmodule

// ===== rtl/track_list_coincidence_finder_top.sv =====
`timescale 1ns / 1ps
// Track list coincidence finder.
// Input beats arrive on s_tvalid/s_tready/s_tdata; each beat clears all three
// lists, writes one slot of one list, queries a slot, or does nothing (spare op).
// Every input beat yields exactly one output beat on m_tvalid/m_tready/m_tdata
// carrying the read value, the bad-index flag, the three valid-prefix counts
// and the first id of list B's prefix that also sits in list C's prefix (and
// in list A's when need_rich is set), or -1.
// cfg_valid/cfg_ready/cfg_data write the out-of-range code; cfg_ready is
// always high. Write it only while the block is idle.
// Timing: one item at a time. Accept, execute, then walk list B one slot per
// cycle comparing against lists A and C in parallel, then load the output
// register. An item's time grows with how far the list B walk runs (it stops
// at the first match or at the end of B's prefix), plus any wait for the
// output register to be free.
// Reset (rst, synchronous) zeroes all lists, sets the out-of-range code to -1
// and drops m_tvalid; s_tready stays low while rst is high. When the receiver
// stalls, the finished beat holds in the output register and the next item is
// still accepted and worked on; it then waits until the output register is free.
module track_list_coincidence_finder_top #(
  parameter int DEPTH_A = 4,
  parameter int DEPTH_B = 4,
  parameter int DEPTH_C = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // op[1:0], list_sel[3:2], slot[7:4], track_id[23:8], need_rich[24], zero pad
  input  logic [31:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // read_value[15:0], bad_index[16], count_a[20:17], count_b[24:21],
  // count_c[28:25], common_id[44:29], zero pad
  output logic [47:0] m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  import tlcf_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  // sequence accept, execute, walk and emit
  tlcf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // hold the lists, the code register and the output beat
  tlcf_datapath #(
    .DEPTH_A (DEPTH_A),
    .DEPTH_B (DEPTH_B),
    .DEPTH_C (DEPTH_C)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

// ===== tb/sv/track_list_coincidence_finder_top_test.sv =====
`timescale 1ns / 1ps
module track_list_coincidence_finder_top_test;
  import tlcf_pkg::*;

  localparam int DEPTH_A = 4;
  localparam int DEPTH_B = 4;
  localparam int DEPTH_C = 4;

  // Codes the package leaves unnamed: the spare op and the spare list select.
  localparam logic [1:0] OP_NONE  = 2'd3;
  localparam logic [1:0] SEL_NONE = 2'd3;

  // Let the walk over list B and the output register drain before touching
  // the out-of-range code.
  localparam int SETTLE_CYCLES = DEPTH_B + 8;

  // One result beat as unpacked fields.
  typedef struct {
    logic signed [IdW-1:0] value;
    logic                  flag;
    logic [3:0]            na;
    logic [3:0]            nb;
    logic [3:0]            nc;
    logic signed [IdW-1:0] common;
  } list_report_t;

  // Predicts the report for every accepted item and checks result beats
  // against the oldest pending report.
  class coincidence_board;
    logic signed [IdW-1:0] ids[3][8];
    int                    depths[3];
    logic signed [IdW-1:0] oor_code;
    list_report_t          reports[$];
    int                    errors;
    int                    checked;
    int                    n_clear;
    int                    n_write;
    int                    n_query;
    int                    n_bad;
    int                    n_common;

    function new();
      depths[0] = DEPTH_A;
      depths[1] = DEPTH_B;
      depths[2] = DEPTH_C;
      foreach (ids[l, s]) ids[l][s] = '0;
      oor_code = ORC_RESET;
    endfunction

    function void set_code(logic signed [IdW-1:0] code);
      oor_code = code;
    endfunction

    function int pending();
      return reports.size();
    endfunction

    function int valid_len(int l);
      for (int i = 0; i < depths[l]; i++) begin
        if (ids[l][i] <= 0) return i;
      end
      return depths[l];
    endfunction

    function bit holds(int l, int n, logic signed [IdW-1:0] id);
      for (int i = 0; i < n; i++) begin
        if (ids[l][i] == id) return 1'b1;
      end
      return 1'b0;
    endfunction

    function void note_item(logic [31:0] beat);
      logic [1:0]            op;
      logic [1:0]            sel;
      logic [3:0]            slot;
      logic signed [IdW-1:0] id;
      logic                  need;
      list_report_t          r;
      logic signed [IdW-1:0] cand;
      op   = beat[1:0];
      sel  = beat[3:2];
      slot = beat[7:4];
      id   = beat[23:8];
      need = beat[24];
      r.value  = '0;
      r.flag   = 1'b0;
      r.common = NO_ID;
      case (op)
        OP_CLEAR: begin
          foreach (ids[l, s]) ids[l][s] = '0;
          n_clear++;
        end
        OP_WRITE: begin
          n_write++;
          if (sel == SEL_NONE) r.flag = 1'b1;
          else if (slot >= depths[sel]) r.flag = 1'b1;
          else ids[sel][slot] = id;
        end
        OP_QUERY: begin
          n_query++;
          if (sel == SEL_NONE) r.flag = 1'b1;
          else if (slot >= depths[sel]) r.flag = 1'b1;
          else r.value = ids[sel][slot];
          if (r.flag) r.value = oor_code;
        end
        default: ;
      endcase
      r.na = 4'(valid_len(0));
      r.nb = 4'(valid_len(1));
      r.nc = 4'(valid_len(2));
      // Walk list B in order; first id present in C (and A when asked) wins.
      for (int i = 0; i < r.nb; i++) begin
        cand = ids[1][i];
        if (holds(2, r.nc, cand) && (!need || holds(0, r.na, cand))) begin
          r.common = cand;
          break;
        end
      end
      if (r.flag) n_bad++;
      if (r.common != NO_ID) n_common++;
      reports.push_back(r);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_result(logic [47:0] beat);
      list_report_t r;
      if (reports.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing outstanding, actual %0h", $time, beat);
        return;
      end
      r = reports.pop_front();
      checked++;
      compare_field("read_value", r.value, beat[15:0]);
      compare_field("bad_index", 16'(r.flag), 16'(beat[16]));
      compare_field("count_a", 16'(r.na), 16'(beat[20:17]));
      compare_field("count_b", 16'(r.nb), 16'(beat[24:21]));
      compare_field("count_c", 16'(r.nc), 16'(beat[28:25]));
      compare_field("common_id", r.common, beat[44:29]);
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  coincidence_board board;

  int items_sent;
  int burst_left;
  int rx_cycle;
  int rx_mode;
  int rx_hold;
  bit rx_low;

  track_list_coincidence_finder_top #(
    .DEPTH_A (DEPTH_A),
    .DEPTH_B (DEPTH_B),
    .DEPTH_C (DEPTH_C)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Generous ceiling: roughly 900 items at worst-case walk, sender gap and
  // receiver stall come to well under half a millisecond; allow ten times.
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Sample both handshakes on the edge; check before noting, since a result
  // beat always belongs to an item accepted on an earlier edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) board.check_result(m_tdata);
      if (s_tvalid && s_tready) board.note_item(s_tdata);
    end
  end

  // Receiver back-pressure: switch mode at random between always ready,
  // coin-flip, mostly stalled and long alternating runs.
  always @(posedge clk) begin
    rx_cycle++;
    if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 3);
    case (rx_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom_range(0, 1));
      2: m_tready <= ($urandom_range(0, 4) == 0);
      default: begin
        if (rx_hold == 0) begin
          rx_hold = $urandom_range(2, 20);
          rx_low  = !rx_low;
        end
        rx_hold--;
        m_tready <= !rx_low;
      end
    endcase
  end

  // Present one input beat and hold it until accepted. Bursts of random
  // length, with random gaps between them; zero-length gaps keep some
  // stretches back to back.
  task automatic issue(logic [1:0] op, logic [1:0] sel, logic [3:0] slot,
                       logic signed [15:0] id, logic need);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'b0, need, id, slot, sel, op};
    do @(posedge clk); while (!s_tready);
    burst_left--;
    items_sent++;
  endtask

  // Drop valid, drain every pending report, let the block settle.
  task automatic drain();
    s_tvalid   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_code(logic signed [15:0] code);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= code;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    board.set_code(code);
  endtask

  // Ids mostly from a small positive pool so lists overlap and matches occur.
  function automatic logic signed [15:0] pick_id();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 16'($urandom);
      2:       return -$signed(16'($urandom_range(1, 3)));
      default: return 16'($urandom_range(1, 6));
    endcase
  endfunction

  function automatic logic [1:0] pick_sel();
    return ($urandom_range(0, 19) == 0) ? SEL_NONE : 2'($urandom_range(0, 2));
  endfunction

  function automatic logic [3:0] pick_slot();
    return ($urandom_range(0, 6) == 0) ? 4'($urandom_range(4, 15))
                                       : 4'($urandom_range(0, 3));
  endfunction

  // Random traffic: mostly list-building episodes with queries mixed in,
  // the rest fully random noise including the spare op and list select.
  task automatic random_phase(int n);
    int stop_at;
    int len;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 9) < 7) begin
        if ($urandom_range(0, 1))
          issue(OP_CLEAR, 2'($urandom), 4'($urandom), 16'($urandom), 1'($urandom));
        len = $urandom_range(3, 12);
        repeat (len) begin
          if ($urandom_range(0, 9) < 3)
            issue(OP_QUERY, pick_sel(), pick_slot(), 16'($urandom), 1'($urandom));
          else
            issue(OP_WRITE, pick_sel(), pick_slot(), pick_id(), 1'($urandom));
        end
      end else begin
        len = $urandom_range(3, 10);
        repeat (len) issue(2'($urandom), 2'($urandom), 4'($urandom), 16'($urandom),
                           1'($urandom));
      end
    end
  endtask

  initial begin
    logic signed [15:0] codes[5];
    board      = new();
    items_sent = 0;
    burst_left = 0;
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed opening under the reset code.
    issue(OP_QUERY, SEL_A, 4'd0, 16'sd0, 1'b0);          // empty lists
    issue(OP_WRITE, SEL_A, 4'd0, 16'sh7fff, 1'b0);
    issue(OP_WRITE, SEL_B, 4'd0, 16'sh7fff, 1'b0);
    issue(OP_WRITE, SEL_C, 4'd0, 16'sh7fff, 1'b1);       // need_rich on a write
    issue(OP_QUERY, SEL_B, 4'd0, 16'sd0, 1'b1);
    issue(OP_WRITE, SEL_A, 4'd3, 16'sh8000, 1'b0);       // most negative id
    issue(OP_WRITE, SEL_B, 4'd1, 16'sd1, 1'b0);
    issue(OP_WRITE, SEL_C, 4'd1, 16'sd1, 1'b0);
    issue(OP_WRITE, SEL_C, 4'd0, 16'sd0, 1'b0);          // zero cuts C's prefix
    issue(OP_QUERY, SEL_C, 4'd3, 16'sd0, 1'b0);
    issue(OP_WRITE, SEL_A, 4'd4, 16'sd5, 1'b0);          // write just past the end
    issue(OP_WRITE, SEL_B, 4'd15, 16'shffff, 1'b1);      // write at the top slot
    issue(OP_QUERY, SEL_A, 4'd15, 16'sd0, 1'b0);         // read past the end
    issue(OP_QUERY, SEL_NONE, 4'd0, 16'sd0, 1'b0);       // read of no list
    issue(OP_WRITE, SEL_NONE, 4'd0, 16'sd7, 1'b0);       // write to no list
    issue(OP_NONE, SEL_NONE, 4'd15, 16'shffff, 1'b1);    // spare op
    issue(OP_WRITE, SEL_C, 4'd0, 16'sd1, 1'b0);
    issue(OP_QUERY, SEL_B, 4'd1, 16'sd0, 1'b1);          // 1 missing from A
    issue(OP_WRITE, SEL_A, 4'd1, 16'sd1, 1'b1);
    issue(OP_WRITE, SEL_B, 4'd2, 16'sd2, 1'b0);
    issue(OP_WRITE, SEL_B, 4'd3, 16'sd3, 1'b0);          // B full
    issue(OP_QUERY, SEL_B, 4'd3, 16'sd0, 1'b1);
    issue(OP_CLEAR, SEL_C, 4'd9, 16'sh1234, 1'b1);
    issue(OP_QUERY, SEL_A, 4'd0, 16'sd0, 1'b0);

    // Random phases, each under its own out-of-range code.
    codes[0] = 16'sh8000;
    codes[1] = 16'sh7fff;
    codes[2] = 16'sd0;
    codes[3] = 16'($urandom);
    codes[4] = ORC_RESET;
    foreach (codes[i]) begin
      write_code(codes[i]);
      random_phase(165);
    end

    drain();
    $display("Sent %0d items (%0d clears, %0d writes, %0d queries), checked %0d results",
             items_sent, board.n_clear, board.n_write, board.n_query, board.checked);
    $display("Out-of-range cases %0d, results with a common id %0d, five code settings",
             board.n_bad, board.n_common);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
